>>> rtl/hse_pkg.sv
package hse_pkg;

  // Store geometry
  localparam int DEPTH = 64;
  localparam int VAL_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // child index arithmetic: 2*pos+2 must fit
  localparam int CMP_W = IDX_W + 2;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMP_W-1:0] cmp_t;

endpackage

>>> rtl/heap_sort_engine.sv
// Channel  Dir  Handshake              tdata         tlast     tuser
// in_      in   in_tvalid/in_tready    value         is_last   -
// out_     out  out_tvalid/out_tready  sorted_value  is_final  overflowed
//
// Steps: one value per transfer while loading; then a build phase sifts down each node
// from n/2 to the root, and each root extraction parks the root at the heap end and sifts
// the former last entry down from the root; then results leave in ascending signed order.
// Reset clears the sequencer, the fill count and the overflow flag; the store is not
// cleared. in_tready is high only while loading; a stalled result holds the sequencer,
// and the final result waits in the output register while the next set already loads.
module heap_sort_engine
  import hse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflowed
);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_SD0   = 4'd1;   // read node that starts a build sift
  localparam logic [3:0] ST_SDCAP = 4'd2;   // capture that node
  localparam logic [3:0] ST_CHK   = 4'd3;   // leaf test, read left child
  localparam logic [3:0] ST_RDR   = 4'd4;   // capture left, read right child
  localparam logic [3:0] ST_CMP   = 4'd5;   // pick largest, move child up
  localparam logic [3:0] ST_X0    = 4'd6;   // shrink heap, read root
  localparam logic [3:0] ST_X1    = 4'd7;   // capture root, read heap end
  localparam logic [3:0] ST_X2    = 4'd8;   // park root at heap end
  localparam logic [3:0] ST_ORD   = 4'd9;   // read next sorted entry
  localparam logic [3:0] ST_OCAP  = 4'd10;  // load output register

  logic [3:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;      // entries held
  cnt_t       hend_r, hend_nxt;    // heap size
  idx_t       pos_r, pos_nxt;      // sift node (hole)
  idx_t       bidx_r, bidx_nxt;    // build node
  logic       build_r, build_nxt;  // sift belongs to build phase
  logic       ovf_r, ovf_nxt;
  idx_t       k_r, k_nxt;          // output index
  val_t       cur_r, cur_nxt;      // value being sifted
  val_t       lval_r, lval_nxt;
  val_t       root_r, root_nxt;

  logic       out_valid_r, out_valid_nxt;
  val_t       out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_user_r, out_user_nxt;

  // store
  val_t       mem [DEPTH];
  val_t       rdata;
  idx_t       rd_addr, wr_addr;
  val_t       wr_data;
  logic       we;

  logic       in_fire;
  cmp_t       left_c, right_c, size_c;
  logic       left_ok, right_ok, big_left, pick_right;
  cnt_t       n_load;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  assign in_fire  = in_tvalid && in_tready;
  assign left_c   = (cmp_t'(pos_r) << 1) + cmp_t'(1);
  assign right_c  = left_c + cmp_t'(1);
  assign size_c   = cmp_t'(hend_r);
  assign left_ok  = left_c < size_c;
  assign right_ok = right_c < size_c;
  assign big_left = $signed(lval_r) > $signed(cur_r);
  assign pick_right = right_ok &&
                      ($signed(rdata) > $signed(big_left ? lval_r : cur_r));
  assign n_load   = (cnt_r < cnt_t'(DEPTH)) ? cnt_r + cnt_t'(1) : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hend_nxt      = hend_r;
    pos_nxt       = pos_r;
    bidx_nxt      = bidx_r;
    build_nxt     = build_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    lval_nxt      = lval_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    rd_addr       = pos_r;
    we            = 1'b0;
    wr_addr       = pos_r;
    wr_data       = cur_r;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_r < cnt_t'(DEPTH)) begin
            we      = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
            wr_data = in_tdata;
            cnt_nxt = n_load;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            hend_nxt  = n_load;
            bidx_nxt  = idx_t'(n_load >> 1);
            pos_nxt   = idx_t'(n_load >> 1);
            build_nxt = 1'b1;
            state_nxt = ST_SD0;
          end
        end
      end
      ST_SD0: begin
        rd_addr   = pos_r;
        state_nxt = ST_SDCAP;
      end
      ST_SDCAP: begin
        cur_nxt   = rdata;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        rd_addr = left_c[IDX_W-1:0];
        if (left_ok) begin
          state_nxt = ST_RDR;
        end else begin
          // leaf: drop the carried value into the hole
          we = 1'b1;
          if (build_r && bidx_r != '0) begin
            bidx_nxt  = bidx_r - idx_t'(1);
            pos_nxt   = bidx_r - idx_t'(1);
            state_nxt = ST_SD0;
          end else begin
            build_nxt = 1'b0;
            state_nxt = ST_X0;
          end
        end
      end
      ST_RDR: begin
        lval_nxt  = rdata;
        rd_addr   = right_c[IDX_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        we = 1'b1;
        if (pick_right) begin
          wr_data   = rdata;
          pos_nxt   = right_c[IDX_W-1:0];
          state_nxt = ST_CHK;
        end else if (big_left) begin
          wr_data   = lval_r;
          pos_nxt   = left_c[IDX_W-1:0];
          state_nxt = ST_CHK;
        end else if (build_r && bidx_r != '0) begin
          bidx_nxt  = bidx_r - idx_t'(1);
          pos_nxt   = bidx_r - idx_t'(1);
          state_nxt = ST_SD0;
        end else begin
          build_nxt = 1'b0;
          state_nxt = ST_X0;
        end
      end
      ST_X0: begin
        rd_addr = '0;
        if (hend_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_ORD;
        end else begin
          hend_nxt  = hend_r - cnt_t'(1);
          state_nxt = ST_X1;
        end
      end
      ST_X1: begin
        root_nxt  = rdata;
        rd_addr   = hend_r[IDX_W-1:0];
        state_nxt = ST_X2;
      end
      ST_X2: begin
        cur_nxt   = rdata;
        we        = 1'b1;
        wr_addr   = hend_r[IDX_W-1:0];
        wr_data   = root_r;
        pos_nxt   = '0;
        state_nxt = ST_CHK;
      end
      ST_ORD: begin
        rd_addr = k_r;
        if (!out_valid_r) begin
          state_nxt = ST_OCAP;
        end
      end
      ST_OCAP: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rdata;
        out_last_nxt  = (cnt_t'(k_r) + cnt_t'(1)) == cnt_r;
        out_user_nxt  = ovf_r;
        if ((cnt_t'(k_r) + cnt_t'(1)) == cnt_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          k_nxt     = k_r + idx_t'(1);
          state_nxt = ST_ORD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      hend_r      <= '0;
      pos_r       <= '0;
      bidx_r      <= '0;
      build_r     <= 1'b0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hend_r      <= hend_nxt;
      pos_r       <= pos_nxt;
      bidx_r      <= bidx_nxt;
      build_r     <= build_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    lval_r     <= lval_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  // fill count never passes the store size
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(DEPTH))
    else $error("fill count beyond store depth");

  // a result only appears after the output capture step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OCAP))
    else $error("result raised outside capture step");

  // sift node stays inside a non-empty heap
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHK || state_r == ST_RDR || state_r == ST_CMP) && hend_r != '0)
    |-> (cnt_t'(pos_r) < hend_r))
    else $error("sift node outside heap");

  // heap size never exceeds the loaded count while sorting
  a_hend_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> (hend_r <= cnt_r))
    else $error("heap size beyond loaded count");
`endif

endmodule
